@@ src/directional_focus_select_assert.svh @@
// Assertion macros for the focus select RTL, included by dfs_back.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef DIRECTIONAL_FOCUS_SELECT_ASSERT_SVH
`define DIRECTIONAL_FOCUS_SELECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("focus select check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DFS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("focus select check failed");

`endif

@@ src/dfs_pkg.sv @@
// Shared types and codes for the directional focus select block.
// No dependencies; used by every module of the block.
`default_nettype none

package dfs_pkg;

	// Item commands.
	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_CAND  = 1'b1;

	// Pressed direction codes.
	localparam logic [1:0] DIR_DOWN  = 2'd0;
	localparam logic [1:0] DIR_UP    = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	// Selection methods.
	localparam logic METHOD_SCORE = 1'b0;
	localparam logic METHOD_LANE  = 1'b1;

	// Fixed field widths.
	localparam int SPAN_W  = 15;
	localparam int INDEX_W = 10;

	// Depth of the queue between front and back; a power of two.
	localparam int QUEUE_DEPTH = 4;

	// Classification of one beat, passed from front to back.
	typedef struct packed {
		logic cand;     // candidate beat (else begin)
		logic method;   // method carried by a begin beat
		logic ignored;  // candidate past capacity
		logic last;     // ends the list
	} ctl_t;

endpackage

`default_nettype wire

@@ src/directional_focus_select.sv @@
// Directional focus select: picks the rectangle a key press moves focus to.
// Throughput: one beat per cycle on both sides while neither side stalls; a four-beat queue separates them.
// A last beat accepted at the input reaches the result register through the queue
// and the scoring stage register; a stall on either side can hold it on the way.
// Reset (arst_n low) clears queue, counts, running best and the origin to empty.
`default_nettype none

module directional_focus_select #(
	parameter int MAX_CANDIDATES = 1024,
	parameter int COORD_BITS     = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         command,
	input  wire logic signed [COORD_BITS-1:0] rect_x,
	input  wire logic signed [COORD_BITS-1:0] rect_y,
	input  wire logic [dfs_pkg::SPAN_W-1:0]   rect_width,
	input  wire logic [dfs_pkg::SPAN_W-1:0]   rect_height,
	input  wire logic [1:0]                   direction,
	input  wire logic                         method,
	input  wire logic                         last,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              found,
	output logic [dfs_pkg::INDEX_W-1:0]       best_index,
	output logic                              overflow
);

	localparam int MW    = (COORD_BITS > 16) ? COORD_BITS : 16;
	localparam int CW    = MW + 1;
	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
	localparam int QW    = $bits(dfs_pkg::ctl_t) + CNT_W + 2 * CW + 2 * dfs_pkg::SPAN_W;

	dfs_pkg::ctl_t               f_ctl;
	logic [CNT_W-1:0]            f_idx;
	logic signed [CW-1:0]        f_l;
	logic signed [CW-1:0]        f_t;
	logic [dfs_pkg::SPAN_W-1:0]  f_w;
	logic [dfs_pkg::SPAN_W-1:0]  f_h;
	dfs_pkg::ctl_t               b_ctl;
	logic [CNT_W-1:0]            b_idx;
	logic signed [CW-1:0]        b_l;
	logic signed [CW-1:0]        b_t;
	logic [dfs_pkg::SPAN_W-1:0]  b_w;
	logic [dfs_pkg::SPAN_W-1:0]  b_h;
	logic                        q_stall;
	logic                        q_valid;
	logic                        b_stall;
	logic [QW-1:0]               push_data;
	logic [QW-1:0]               pop_data;

	assign in_stall  = q_stall;
	assign push_data = {f_ctl, f_idx, f_l, f_t, f_w, f_h};
	assign {b_ctl, b_idx, b_l, b_t, b_w, b_h} = pop_data;

	// Front: orientation and numbering of incoming beats.
	dfs_front #(
		.COORD_BITS     (COORD_BITS),
		.MAX_CANDIDATES (MAX_CANDIDATES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.q_stall     (q_stall),
		.command     (command),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.direction   (direction),
		.method      (method),
		.last        (last),
		.item_ctl    (f_ctl),
		.item_idx    (f_idx),
		.item_l      (f_l),
		.item_t      (f_t),
		.item_w      (f_w),
		.item_h      (f_h)
	);

	// Queue between front and back.
	dfs_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_stall (q_stall),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_stall  (b_stall),
		.pop_data   (pop_data)
	);

	// Back: scoring, running best and result.
	dfs_back #(
		.COORD_BITS     (COORD_BITS),
		.MAX_CANDIDATES (MAX_CANDIDATES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_stall (b_stall),
		.item_ctl   (b_ctl),
		.item_idx   (b_idx),
		.item_l     (b_l),
		.item_t     (b_t),
		.item_w     (b_w),
		.item_h     (b_h),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.best_index (best_index),
		.overflow   (overflow)
	);

endmodule

`default_nettype wire

@@ src/dfs_queue.sv @@
// Short first-in first-out queue between the front and back parts.
// Depends on dfs_pkg for the queue depth.
`default_nettype none

module dfs_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_stall,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_stall,
	output logic      [WIDTH-1:0] pop_data
);

	localparam int DEPTH = dfs_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push;
	logic             pop;

	// Full and empty come straight from the fill count.
	assign push_stall = (count_q == (PTR_W + 1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && !push_stall;
	assign pop        = pop_valid && !pop_stall;

	// Storage is written at the tail only.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap naturally since the depth is a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/dfs_front.sv @@
// Front part: accepts beats, orients each rectangle so the press points down,
// and numbers candidates. Depends on dfs_pkg.
`default_nettype none

module dfs_front #(
	parameter int COORD_BITS     = 16,
	parameter int MAX_CANDIDATES = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          q_stall,
	input  wire logic                          command,
	input  wire logic signed [COORD_BITS-1:0]  rect_x,
	input  wire logic signed [COORD_BITS-1:0]  rect_y,
	input  wire logic [dfs_pkg::SPAN_W-1:0]    rect_width,
	input  wire logic [dfs_pkg::SPAN_W-1:0]    rect_height,
	input  wire logic [1:0]                    direction,
	input  wire logic                          method,
	input  wire logic                          last,
	output dfs_pkg::ctl_t                      item_ctl,
	output logic [$clog2(MAX_CANDIDATES+1)-1:0] item_idx,
	output logic signed [((COORD_BITS > 16) ? COORD_BITS : 16):0] item_l,
	output logic signed [((COORD_BITS > 16) ? COORD_BITS : 16):0] item_t,
	output logic [dfs_pkg::SPAN_W-1:0]         item_w,
	output logic [dfs_pkg::SPAN_W-1:0]         item_h
);

	localparam int MW    = (COORD_BITS > 16) ? COORD_BITS : 16;
	localparam int CW    = MW + 1;
	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

	logic [1:0]             dir_q;
	logic [1:0]             dir_use;
	logic [CNT_W-1:0]       count_q;
	logic                   accept;
	logic                   ignored;
	logic signed [CW-1:0]   xs;
	logic signed [CW-1:0]   ys;
	logic signed [CW-1:0]   ws;
	logic signed [CW-1:0]   hs;

	assign accept  = in_valid && !q_stall;
	assign dir_use = (command == dfs_pkg::CMD_BEGIN) ? direction : dir_q;
	assign ignored = (command == dfs_pkg::CMD_CAND) &&
		(count_q >= CNT_W'(MAX_CANDIDATES));

	assign xs = CW'(rect_x);
	assign ys = CW'(rect_y);
	assign ws = $signed(CW'(rect_width));
	assign hs = $signed(CW'(rect_height));

	// Rotate or mirror the rectangle so that the press points down.
	always_comb begin
		unique case (dir_use)
			dfs_pkg::DIR_UP: begin
				item_l = xs;
				item_t = -(ys + hs);
				item_w = rect_width;
				item_h = rect_height;
			end
			dfs_pkg::DIR_RIGHT: begin
				item_l = ys;
				item_t = xs;
				item_w = rect_height;
				item_h = rect_width;
			end
			dfs_pkg::DIR_LEFT: begin
				item_l = ys;
				item_t = -(xs + ws);
				item_w = rect_height;
				item_h = rect_width;
			end
			default: begin
				item_l = xs;
				item_t = ys;
				item_w = rect_width;
				item_h = rect_height;
			end
		endcase
	end

	// Classification that travels with the beat.
	always_comb begin
		item_ctl.cand    = command;
		item_ctl.method  = method;
		item_ctl.ignored = ignored;
		item_ctl.last    = last;
		item_idx         = count_q;
	end

	// Direction is latched on begin; the position count restarts on begin and
	// after the last beat, and saturates at capacity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= dfs_pkg::DIR_DOWN;
			count_q <= '0;
		end else if (accept) begin
			if (command == dfs_pkg::CMD_BEGIN) begin
				dir_q <= direction;
			end
			if (command == dfs_pkg::CMD_BEGIN || last) begin
				count_q <= '0;
			end else if (!ignored) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/dfs_back.sv @@
// Back part: qualifies and scores oriented candidates, keeps the running best
// and registers one result per list. Depends on dfs_pkg and the assert macros.
`default_nettype none
`include "directional_focus_select_assert.svh"

module dfs_back #(
	parameter int COORD_BITS     = 16,
	parameter int MAX_CANDIDATES = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire dfs_pkg::ctl_t                 item_ctl,
	input  wire logic [$clog2(MAX_CANDIDATES+1)-1:0] item_idx,
	input  wire logic signed [((COORD_BITS > 16) ? COORD_BITS : 16):0] item_l,
	input  wire logic signed [((COORD_BITS > 16) ? COORD_BITS : 16):0] item_t,
	input  wire logic [dfs_pkg::SPAN_W-1:0]    item_w,
	input  wire logic [dfs_pkg::SPAN_W-1:0]    item_h,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               found,
	output logic [dfs_pkg::INDEX_W-1:0]        best_index,
	output logic                               overflow
);

	localparam int MW    = (COORD_BITS > 16) ? COORD_BITS : 16;
	localparam int CW    = MW + 1;
	localparam int EW    = MW + 3;
	localparam int LW    = MW + 2;
	localparam int SW    = MW + 6;
	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
	localparam int XW    = (CNT_W > dfs_pkg::INDEX_W) ? CNT_W : dfs_pkg::INDEX_W;
	localparam logic signed [EW-1:0] ZERO = '0;
	localparam logic signed [EW-1:0] ONE  = EW'(1);
	localparam logic signed [EW-1:0] TWO  = EW'(2);

	// Oriented origin and method of the current query.
	logic signed [CW-1:0]          org_l_q;
	logic signed [CW-1:0]          org_t_q;
	logic [dfs_pkg::SPAN_W-1:0]    org_w_q;
	logic [dfs_pkg::SPAN_W-1:0]    org_h_q;
	logic                          method_q;

	// Scoring stage.
	logic                          v_s2;
	dfs_pkg::ctl_t                 ctl_s2;
	logic [CNT_W-1:0]              idx_s2;
	logic                          qual_s2;
	logic                          method_s2;
	logic [SW-1:0]                 score_s2;
	logic [LW-1:0]                 lane_s2;
	logic [LW-1:0]                 gap_s2;

	// Running best.
	logic                          have_best_q;
	logic [CNT_W-1:0]              win_idx_q;
	logic [SW-1:0]                 win_score_q;
	logic [LW-1:0]                 win_lane_q;
	logic [LW-1:0]                 win_gap_q;
	logic                          ovf_q;

	// Output register.
	logic                          out_valid_q;
	logic                          found_q;
	logic [dfs_pkg::INDEX_W-1:0]   best_index_q;
	logic                          overflow_q;

	logic                          en;
	logic                          pop;
	logic signed [EW-1:0]          tl, tt, tw, th, fl, ft, fw, fh;
	logic signed [EW-1:0]          tr, tb, fr, fb, lo, hi, ov, gap_raw, off_raw;
	logic [EW-1:0]                 off_mag;
	logic [dfs_pkg::SPAN_W-1:0]    narrower;
	logic [dfs_pkg::SPAN_W-1:0]    shared;
	logic [LW-1:0]                 lane;
	logic [LW-1:0]                 gap;
	logic [SW-1:0]                 score;
	logic                          nonempty;
	logic                          ahead;
	logic                          qual;
	logic                          better;
	logic                          win;
	logic                          have_pre;
	logic [CNT_W-1:0]              idx_pre;
	logic                          ovf_pre;
	logic [XW-1:0]                 idx_ext;

	// The whole back part moves unless a result waits and is held off.
	assign en         = !(out_valid_q && out_stall);
	assign item_stall = !en;
	assign pop        = item_valid && en;

	// Edges of both oriented rectangles.
	always_comb begin
		tl = EW'(item_l);
		tt = EW'(item_t);
		tw = $signed(EW'(item_w));
		th = $signed(EW'(item_h));
		fl = EW'(org_l_q);
		ft = EW'(org_t_q);
		fw = $signed(EW'(org_w_q));
		fh = $signed(EW'(org_h_q));
		tr = tl + tw;
		tb = tt + th;
		fr = fl + fw;
		fb = ft + fh;
		lo = (fl > tl) ? fl : tl;
		hi = (fr < tr) ? fr : tr;
		ov = hi - lo;
		gap_raw = tt - fb;
		off_raw = (tl + tl + tw) - (fl + fl + fw);
	end

	// Gap, overlap, lane distance and score of the queue head.
	always_comb begin
		nonempty = (item_w != '0) && (item_h != '0) && (org_w_q != '0) && (org_h_q != '0);
		ahead    = ((tt + tt + th) > (ft + ft + fh + TWO)) &&
			((tb > fb + ONE) || (tt > ft + ONE));
		gap      = (gap_raw > ZERO) ? LW'(gap_raw) : '0;
		shared   = (ov > ZERO) ? dfs_pkg::SPAN_W'(ov) : '0;
		lane     = (ov < ZERO) ? LW'(-ov) : '0;
		narrower = (item_w < org_w_q) ? item_w : org_w_q;
		off_mag  = (off_raw < ZERO) ? EW'(-off_raw) : EW'(off_raw);
		score    = (SW'(gap) << 3) + (SW'(narrower - shared) << 2) + SW'(off_mag);
		qual     = (item_ctl.cand == dfs_pkg::CMD_CAND) && !item_ctl.ignored &&
			nonempty && ahead && ((method_q == dfs_pkg::METHOD_LANE) || (ov > ZERO));
	end

	// Origin is taken when a begin beat leaves the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_l_q  <= '0;
			org_t_q  <= '0;
			org_w_q  <= '0;
			org_h_q  <= '0;
			method_q <= dfs_pkg::METHOD_SCORE;
		end else if (pop && item_ctl.cand == dfs_pkg::CMD_BEGIN) begin
			org_l_q  <= item_l;
			org_t_q  <= item_t;
			org_w_q  <= item_w;
			org_h_q  <= item_h;
			method_q <= item_ctl.method;
		end
	end

	// Scoring stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2      <= 1'b0;
			ctl_s2    <= '0;
			idx_s2    <= '0;
			qual_s2   <= 1'b0;
			method_s2 <= dfs_pkg::METHOD_SCORE;
			score_s2  <= '0;
			lane_s2   <= '0;
			gap_s2    <= '0;
		end else if (en) begin
			v_s2      <= item_valid;
			ctl_s2    <= item_ctl;
			idx_s2    <= item_idx;
			qual_s2   <= qual;
			method_s2 <= method_q;
			score_s2  <= score;
			lane_s2   <= lane;
			gap_s2    <= gap;
		end
	end

	// Compare against the running best; the earlier candidate keeps a tie.
	always_comb begin
		if (method_s2 == dfs_pkg::METHOD_SCORE) begin
			better = score_s2 < win_score_q;
		end else begin
			better = ((LW + 1)'(lane_s2) + 1'b1 < (LW + 1)'(win_lane_q)) ||
				((lane_s2 <= win_lane_q) && (gap_s2 < win_gap_q));
		end
		win = qual_s2 && (!have_best_q || better);
		if (ctl_s2.cand == dfs_pkg::CMD_BEGIN) begin
			have_pre = 1'b0;
			idx_pre  = '0;
			ovf_pre  = 1'b0;
		end else begin
			have_pre = have_best_q || win;
			idx_pre  = win ? idx_s2 : win_idx_q;
			ovf_pre  = ovf_q || ctl_s2.ignored;
		end
		idx_ext = XW'(idx_pre);
	end

	// Running best and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q  <= 1'b0;
			win_idx_q    <= '0;
			win_score_q  <= '0;
			win_lane_q   <= '0;
			win_gap_q    <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			best_index_q <= '0;
			overflow_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (en && v_s2) begin
				if (ctl_s2.last || ctl_s2.cand == dfs_pkg::CMD_BEGIN) begin
					have_best_q <= 1'b0;
					win_idx_q   <= '0;
					win_score_q <= '0;
					win_lane_q  <= '0;
					win_gap_q   <= '0;
					ovf_q       <= 1'b0;
				end else begin
					have_best_q <= have_pre;
					win_idx_q   <= idx_pre;
					ovf_q       <= ovf_pre;
					if (win) begin
						win_score_q <= score_s2;
						win_lane_q  <= lane_s2;
						win_gap_q   <= gap_s2;
					end
				end
				if (ctl_s2.last) begin
					out_valid_q  <= 1'b1;
					found_q      <= have_pre;
					best_index_q <= have_pre ? idx_ext[dfs_pkg::INDEX_W-1:0] : '0;
					overflow_q   <= ovf_pre;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign best_index = best_index_q;
	assign overflow   = overflow_q;

	// A result without a winner reports index zero.
	`DFS_ASSERT_IMP(a_none_zero_index, out_valid_q && !found_q, best_index_q == '0)
	// A held-off scoring stage keeps its beat.
	`DFS_ASSERT_NXT(a_stage_holds, v_s2 && !en, v_s2 && $stable(score_s2) && $stable(idx_s2))
	// A kept winner always lies inside capacity.
	`DFS_ASSERT_IMP(a_win_in_range, have_best_q, win_idx_q < CNT_W'(MAX_CANDIDATES))

endmodule

`default_nettype wire
